// File: rtl/core/qdz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdz_pkg: shared types and constants of the quadrature decoder with zones
// Holds the transfer payload structs, quadrant codes, pin codes, register
// index and the constants of the zone divider.
// ----------------------------------------------------------------------------
package qdz_pkg;

  // field widths
  localparam int unsigned PinW   = 2;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PosW   = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned ZoneW  = 3;
  localparam int unsigned QuadW  = 2;
  localparam int unsigned DataW  = 32;

  // configuration port: one register at byte address 0
  localparam int unsigned CfgAddrW = 3;
  localparam logic        RegGuardTime = 1'b0;

  // pin codes
  localparam logic [PinW-1:0] PinPhaseA = 2'd0;
  localparam logic [PinW-1:0] PinPhaseB = 2'd1;

  // zone geometry
  localparam int unsigned CountsPerRev = 17280;
  localparam int unsigned ZoneLast     = 7;
  localparam int unsigned ZoneRaw      = CountsPerRev / (ZoneLast + 1);
  localparam int unsigned ZoneSize     = (ZoneRaw == 0) ? 1 : ZoneRaw;
  localparam int unsigned CprW         = $clog2(CountsPerRev + 1);
  localparam int unsigned ZsW          = $clog2(ZoneSize + 1);

  // remainder widths: final remainder below CountsPerRev, raw one below twice that
  localparam int unsigned RemW = $clog2(CountsPerRev);
  localparam int unsigned RawW = RemW + 1;

  // reciprocal for the magnitude modulo: floor(2^32 / CountsPerRev)
  localparam longint unsigned Recip1 = (64'd1 << PosW) / CountsPerRev;
  localparam int unsigned     Recip1W = $clog2(Recip1 + 1);
  localparam int unsigned     Prod1W  = PosW + Recip1W;

  // reciprocal for the zone quotient: floor(2^RemW / ZoneSize)
  localparam longint unsigned Recip2 = (64'd1 << RemW) / ZoneSize;
  localparam int unsigned     Recip2W = $clog2(Recip2 + 1);
  localparam int unsigned     Prod2W  = RemW + Recip2W;

  // quadrature states
  typedef enum logic [QuadW-1:0] {
    Q1 = 2'd0,
    Q2 = 2'd1,
    Q3 = 2'd2,
    Q4 = 2'd3
  } quad_e;

  // input transfer payload
  typedef struct packed {
    logic [PinW-1:0]  pin_select;
    logic             edge_rising;
    logic [TimeW-1:0] time_us;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic                   accepted;
    logic signed [PosW-1:0] position_out;
    logic [ZoneW-1:0]       zone_out;
    logic [QuadW-1:0]       quadrant_out;
    logic [CntW-1:0]        ignored_total;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/quadrature_decoder_with_zones.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_decoder_with_zones: x4 quadrature decoder with debounce and zones
// Edge events pass a guard-time check, step the quadrant state machine and
// the signed position; a short pipeline then derives the zone of the position.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid_i/in_ready_o   in_data_i  (in_item_t)
//  out       output     out_valid_o/out_ready_i out_data_o (out_item_t)
//  cfg       input      psel/penable/pwrite     paddr, pwdata, prdata
//
//  one item per cycle while the output is not held back; a result passes the
//  input register, the state update (guard check, quadrant, position), the
//  four zone divider stages of reciprocal multiply and the result register
//  reset clears state, counters and the guard time; no clearing pass
//  when the output is held, every stage holds and the input takes at most
//  one more item into its register
// ----------------------------------------------------------------------------
module quadrature_decoder_with_zones
  import qdz_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_data_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_data_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  // fields carried along the zone pipeline
  typedef struct packed {
    logic            accepted;
    logic [PosW-1:0] position;
    quad_e           quadrant;
    logic [CntW-1:0] ignored;
    logic            neg;
  } carry_t;

  localparam int unsigned NumStages = 5;

  logic [TimeW-1:0] guard_q;
  logic             v0_q;
  in_item_t         in_q;
  quad_e            quad_q, quad_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [TimeW-1:0] last_q;
  logic [CntW-1:0]  ign_q, ign_d;

  logic             adv;
  logic             core_fire;
  logic             pass;
  logic [TimeW-1:0] limit;
  logic             is_a, is_b, rise;

  logic [NumStages:1] v_q;
  carry_t             carry_q [1:NumStages];
  carry_t             carry_d;
  logic [PosW-1:0]    mag_d, mag1_q, mag2_q;
  logic [Prod1W-1:0]  prod1_d, prod1_q;
  logic [Recip1W-1:0] qa;
  logic [Recip1W+CprW-1:0] qa_mul;
  logic [PosW-1:0]    r_full;
  logic [RawW-1:0]    raw_q;
  logic [RemW-1:0]    rc_d, rc_q, rc5_q;
  logic [Prod2W-1:0]  prod2_d, prod2_q;
  logic [Recip2W-1:0] q2;
  logic [Recip2W+ZsW-1:0] q2_mul;
  logic [RemW-1:0]    r2;
  logic [Recip2W-1:0] q_fix;
  logic [ZoneW-1:0]   zone;

  logic      out_valid_q;
  out_item_t out_q;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[CfgAddrW-1] == RegGuardTime) ? guard_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[CfgAddrW-1] == RegGuardTime)) begin
      guard_q <= pwdata;
    end
  end

  // pipeline advances whenever the result register is free or being taken
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !v0_q || adv;
  assign core_fire  = v0_q && adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (in_ready_o) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // guard check: a wrapped sum above the timestamp rejects the edge
  assign limit = last_q + guard_q;
  assign pass  = !(limit > in_q.time_us);
  assign is_a  = (in_q.pin_select == PinPhaseA);
  assign is_b  = (in_q.pin_select == PinPhaseB);
  assign rise  = in_q.edge_rising;

  // quadrant state machine and position step
  always_comb begin
    quad_d = quad_q;
    pos_d  = pos_q;
    if (pass) begin
      unique case (quad_q)
        Q1: begin
          if (is_b && rise) begin
            quad_d = Q2;
            pos_d  = pos_q + 1'b1;
          end else if (is_a && rise) begin
            quad_d = Q4;
            pos_d  = pos_q - 1'b1;
          end
        end
        Q2: begin
          if (is_b && !rise) begin
            quad_d = Q1;
            pos_d  = pos_q - 1'b1;
          end else if (is_a && rise) begin
            quad_d = Q3;
            pos_d  = pos_q + 1'b1;
          end
        end
        Q3: begin
          if (is_b && !rise) begin
            quad_d = Q4;
            pos_d  = pos_q + 1'b1;
          end else if (is_a && !rise) begin
            quad_d = Q2;
            pos_d  = pos_q - 1'b1;
          end
        end
        Q4: begin
          if (is_a && !rise) begin
            quad_d = Q1;
            pos_d  = pos_q + 1'b1;
          end else if (is_b && rise) begin
            quad_d = Q3;
            pos_d  = pos_q - 1'b1;
          end
        end
        default: begin
          quad_d = quad_q;
        end
      endcase
    end
  end

  assign ign_d = pass ? ign_q : ign_q + 1'b1;

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= Q1;
      pos_q  <= '0;
      last_q <= '0;
      ign_q  <= '0;
    end else if (core_fire) begin
      quad_q <= quad_d;
      pos_q  <= pos_d;
      ign_q  <= ign_d;
      if (pass) begin
        last_q <= in_q.time_us;
      end
    end
  end

  // result fields and magnitude for the zone divider
  always_comb begin
    carry_d.accepted = pass;
    carry_d.position = pos_d;
    carry_d.quadrant = quad_d;
    carry_d.ignored  = ign_d;
    carry_d.neg      = pos_d[PosW-1];
    mag_d            = pos_d[PosW-1] ? (~pos_d + 1'b1) : pos_d;
  end

  // valid bits of the zone pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NumStages-1:1], v0_q};
    end
  end

  // stage 2: magnitude times reciprocal of counts per revolution
  assign prod1_d = mag1_q * Recip1W'(Recip1);

  // stage 3: raw remainder, below twice counts per revolution
  assign qa     = prod1_q[Prod1W-1:PosW];
  assign qa_mul = qa * CprW'(CountsPerRev);
  assign r_full = mag2_q - PosW'(qa_mul);

  // stage 4: one correction step gives the remainder
  assign rc_d = (raw_q >= RawW'(CountsPerRev)) ? RemW'(raw_q - RawW'(CountsPerRev))
                                               : RemW'(raw_q);

  // stage 5: remainder times reciprocal of zone size
  assign prod2_d = rc5_q * Recip2W'(Recip2);

  // output stage: quotient correction and mirror for negative positions
  assign q2     = prod2_q[Prod2W-1:RemW];
  assign q2_mul = q2 * ZsW'(ZoneSize);
  assign r2     = rc_q - RemW'(q2_mul);
  assign q_fix  = (r2 >= RemW'(ZoneSize)) ? q2 + 1'b1 : q2;
  assign zone   = carry_q[NumStages].neg ? ZoneW'(ZoneLast) - ZoneW'(q_fix)
                                         : ZoneW'(q_fix);

  // pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      carry_q[1] <= carry_d;
      mag1_q     <= mag_d;
      for (int i = 2; i <= NumStages; i++) begin
        carry_q[i] <= carry_q[i-1];
      end
      prod1_q <= prod1_d;
      mag2_q  <= mag1_q;
      raw_q   <= RawW'(r_full);
      rc5_q   <= rc_d;
      prod2_q <= prod2_d;
      rc_q    <= rc5_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v_q[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.accepted      <= carry_q[NumStages].accepted;
      out_q.position_out  <= carry_q[NumStages].position;
      out_q.zone_out      <= zone;
      out_q.quadrant_out  <= carry_q[NumStages].quadrant;
      out_q.ignored_total <= carry_q[NumStages].ignored;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a quadrant change always comes with a single count step
  a_quad_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quad_q != $past(quad_q)) |->
      (pos_q == $past(pos_q) + 1'b1 || pos_q == $past(pos_q) - 1'b1))
    else $error("quadrant changed without a single position step");

  // a rejected edge bumps the ignored counter
  a_ignore_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_fire && !pass) |=> (ign_q == $past(ign_q) + 1'b1))
    else $error("rejected edge not counted");

  // the stored timestamp changes only on a core update
  a_last_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q != $past(last_q)) |-> $past(core_fire))
    else $error("last accept time changed without an update");

  // corrected remainder stays below counts per revolution
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (rc5_q < RemW'(CountsPerRev)))
    else $error("zone remainder out of range");

  // input stalls only while a result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

endmodule
`default_nettype wire
